// ----- rtl/core/egbr_pkg.sv -----
// shared types and constants for the exp-golomb bit reader
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package egbr_pkg;

  // request codes
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_BITS   = 3'd2;
  localparam logic [2:0] REQ_UE     = 3'd3;
  localparam logic [2:0] REQ_SE     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_END       = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // widest raw read and prefix length limit
  localparam logic [5:0] MAX_READ = 6'd32;
  localparam logic [6:0] ZERO_LIMIT = 7'd33;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TAKE   = 7'b0000010,
    S_PREFIX = 7'b0000100,
    S_SUFCHK = 7'b0001000,
    S_CODE   = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  // leading zeros of a byte, 8 when the byte is zero
  function automatic logic [3:0] lead_zeros8(input logic [7:0] v);
    logic [3:0] n;
    logic       seen;
    n    = 4'd0;
    seen = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!seen) begin
        if (v[i]) begin
          seen = 1'b1;
        end else begin
          n = n + 4'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/egbr_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module egbr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/exp_golomb_bit_reader_unit.sv -----
// exp-golomb bit reader: byte store, msb-first read position, raw/ue/se reads
// depends on egbr_pkg and egbr_ram
// one request at a time, paced by the one-byte store read; clear and append return no result
// a raw read steps through the bytes it touches; a ue or se read steps through the prefix bytes,
// then the suffix bytes, and stops early when the prefix fails or the suffix is short
// reset clears the fill count, the read position and result valid; the store is never cleared
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_bit_reader_unit
  import egbr_pkg::*;
#(
  parameter int BUF_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [2:0]         req_type,
  input  wire logic [7:0]         byte_value,
  input  wire logic [5:0]         bit_count,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic      [1:0]         status,
  output logic      [31:0]        unsigned_value,
  output logic signed [31:0]      signed_value,
  output logic      [15:0]        error_bit_offset
);

  localparam int FILL_W = $clog2(BUF_BYTES + 1);
  localparam int AW     = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int POS_W  = FILL_W + 3;
  localparam int CMP_W  = (POS_W > 6) ? POS_W : 6;

  // low 16 bits of a bit offset, whatever the position width
  function automatic logic [15:0] off16(input logic [POS_W-1:0] p);
    logic [POS_W+15:0] t;
    t = {16'b0, p};
    return t[15:0];
  endfunction

  // control state
  state_t           state, state_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [POS_W-1:0] pos, pos_next;

  // working registers of the current read
  logic [5:0]  need, need_next;      // bits still to take
  logic [5:0]  zeros, zeros_next;    // prefix zeros seen so far
  logic [31:0] acc, acc_next;        // raw bits or suffix
  logic [32:0] code, code_next;      // full exp-golomb code number
  logic        is_fixed, is_fixed_next;
  logic        is_se, is_se_next;

  // pending result
  logic [1:0]  r_status, r_status_next;
  logic [31:0] r_uval, r_uval_next;
  logic [31:0] r_sval, r_sval_next;
  logic [15:0] r_err, r_err_next;
  logic        res_valid_next;
  logic        out_load;

  // store port
  logic          wr_en;
  logic [7:0]    rdata;

  // total bits held and bits left after the read position
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] rem;
  assign total = {fill, 3'b000};
  assign rem   = total - pos;

  // one byte step: rdata always holds the byte under the read position
  logic [2:0]  bit_off;
  logic [3:0]  avail;
  logic [7:0]  aligned;
  logic [3:0]  take_k;
  logic [7:0]  take_bits;
  logic [31:0] acc_step;
  logic [3:0]  lz;
  logic        found;
  logic [3:0]  zr;
  logic [6:0]  zsum;
  logic [5:0]  ovf_inc;
  logic [32:0] eg_mask;
  logic [31:0] half;

  assign bit_off   = pos[2:0];
  assign avail     = 4'd8 - {1'b0, bit_off};
  assign aligned   = rdata << bit_off;
  assign take_k    = (need < {2'b0, avail}) ? need[3:0] : avail;
  assign take_bits = aligned >> (4'd8 - take_k);
  assign acc_step  = (acc << take_k) | {24'b0, take_bits};
  // zero fill below the aligned bits makes a count at or past avail mean no one here
  assign lz        = lead_zeros8(aligned);
  assign found     = (lz < avail);
  assign zr        = found ? lz : avail;
  assign zsum      = {1'b0, zeros} + {3'b0, zr};
  assign ovf_inc   = 6'd33 - zeros;
  // 2^zeros - 1 as a mask
  assign eg_mask   = ~(33'h1_FFFF_FFFF << zeros);
  assign half      = code[32:1];

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    pos_next       = pos;
    need_next      = need;
    zeros_next     = zeros;
    acc_next       = acc;
    code_next      = code;
    is_fixed_next  = is_fixed;
    is_se_next     = is_se;
    r_status_next  = r_status;
    r_uval_next    = r_uval;
    r_sval_next    = r_sval;
    r_err_next     = r_err;
    wr_en          = 1'b0;
    out_load       = 1'b0;
    res_valid_next = res_valid;

    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          r_status_next = ST_OK;
          r_uval_next   = 32'd0;
          r_sval_next   = 32'd0;
          r_err_next    = 16'd0;
          acc_next      = 32'd0;
          case (req_type)
            REQ_CLEAR: begin
              fill_next = '0;
              pos_next  = '0;
            end
            REQ_APPEND: begin
              // a full store ignores the byte
              if (fill < FILL_W'(BUF_BYTES)) begin
                wr_en     = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            REQ_BITS: begin
              is_fixed_next = 1'b1;
              is_se_next    = 1'b0;
              if (bit_count > MAX_READ) begin
                r_status_next = ST_BAD_COUNT;
                r_err_next    = off16(pos);
                state_next    = S_DONE;
              end else if (CMP_W'(bit_count) > CMP_W'(rem)) begin
                r_status_next = ST_END;
                r_err_next    = off16(total);
                state_next    = S_DONE;
              end else if (bit_count == 6'd0) begin
                state_next = S_DONE;
              end else begin
                need_next  = bit_count;
                state_next = S_TAKE;
              end
            end
            REQ_UE, REQ_SE: begin
              is_fixed_next = 1'b0;
              is_se_next    = (req_type == REQ_SE);
              zeros_next    = 6'd0;
              state_next    = S_PREFIX;
            end
            default: begin
            end
          endcase
        end
      end

      S_TAKE: begin
        // bits were checked to be present before entry
        acc_next  = acc_step;
        need_next = need - {2'b0, take_k};
        pos_next  = pos + POS_W'(take_k);
        if (need == {2'b0, take_k}) begin
          if (is_fixed) begin
            r_uval_next = acc_step;
            state_next  = S_DONE;
          end else begin
            state_next = S_CODE;
          end
        end
      end

      S_PREFIX: begin
        if (pos == total) begin
          // prefix ran out; zeros already read stay consumed
          r_status_next = ST_END;
          r_err_next    = off16(total);
          state_next    = S_DONE;
        end else if (zsum >= ZERO_LIMIT) begin
          // 33rd zero reached: consume up to and including it
          pos_next      = pos + POS_W'(ovf_inc);
          r_status_next = ST_OVERFLOW;
          r_err_next    = off16(pos + POS_W'(ovf_inc));
          state_next    = S_DONE;
        end else if (found) begin
          zeros_next = zeros + {2'b0, lz};
          pos_next   = pos + POS_W'(lz) + 1'b1;
          state_next = S_SUFCHK;
        end else begin
          zeros_next = zeros + {2'b0, avail};
          pos_next   = pos + POS_W'(avail);
        end
      end

      S_SUFCHK: begin
        acc_next = 32'd0;
        if (CMP_W'(zeros) > CMP_W'(rem)) begin
          // suffix missing: prefix stays consumed, suffix untouched
          r_status_next = ST_END;
          r_err_next    = off16(total);
          state_next    = S_DONE;
        end else if (zeros == 6'd0) begin
          state_next = S_CODE;
        end else begin
          need_next  = zeros;
          state_next = S_TAKE;
        end
      end

      S_CODE: begin
        code_next  = eg_mask + {1'b0, acc};
        state_next = S_EVAL;
      end

      S_EVAL: begin
        state_next = S_DONE;
        if (!is_se) begin
          if (code[32]) begin
            r_status_next = ST_OVERFLOW;
            r_err_next    = off16(pos);
          end else begin
            r_uval_next = code[31:0];
          end
        end else if (code[0]) begin
          // odd codes map to positive values
          if (half >= 32'h7FFF_FFFF) begin
            r_status_next = ST_OVERFLOW;
            r_err_next    = off16(pos);
          end else begin
            r_sval_next = half + 32'd1;
          end
        end else begin
          if (half > 32'h8000_0000) begin
            r_status_next = ST_OVERFLOW;
            r_err_next    = off16(pos);
          end else begin
            r_sval_next = 32'd0 - half;
          end
        end
      end

      S_DONE: begin
        // wait for the result register to be free
        if (!res_valid || res_ready) begin
          out_load       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // store: always read the byte under the next read position
  egbr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (byte_value),
    .rd_addr (pos_next[AW+2:3]),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      pos       <= pos_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    need     <= need_next;
    zeros    <= zeros_next;
    acc      <= acc_next;
    code     <= code_next;
    is_fixed <= is_fixed_next;
    is_se    <= is_se_next;
    r_status <= r_status_next;
    r_uval   <= r_uval_next;
    r_sval   <= r_sval_next;
    r_err    <= r_err_next;
    if (out_load) begin
      status           <= r_status;
      unsigned_value   <= r_uval;
      signed_value     <= $signed(r_sval);
      error_bit_offset <= r_err;
    end
  end

endmodule

`default_nettype wire
